>>> src/samt_pkg.sv
`timescale 1ns / 1ps
// samt_pkg: shared constants, codes and types of the sorted address map table
// no dependencies; every other file of the block but samt_ram imports it

package samt_pkg;

   localparam int MAP_SLOTS   = 16;
   localparam int IDX_W       = $clog2(MAP_SLOTS);
   localparam int CNT_W       = $clog2(MAP_SLOTS + 1);
   localparam int ADDR_W      = 64;
   localparam int LEN_W       = 32;
   localparam int NUM_W       = 6;
   localparam int MOD_W       = 4;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int PROD_W      = MOD_W + LEN_W;
   localparam int ENTRY_W     = MOD_W + ADDR_W + LEN_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_BASE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SIZE = CSR_INDEX_W'(1);

   localparam logic [ADDR_W-1:0] PAGE_BASE_RESET = '0;
   localparam logic [LEN_W-1:0]  PAGE_SIZE_RESET = LEN_W'(4096);

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD,
      KIND_REMOVE,
      KIND_LOOKUP_ADDR,
      KIND_LOOKUP_NUM
   } samt_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_BAD_NUM,
      STATUS_OVERLAP,
      STATUS_NOT_FOUND,
      STATUS_FULL
   } samt_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_MUL,
      ST_PREP_PAGE,
      ST_PREP_END,
      ST_SCAN,
      ST_SHIFT,
      ST_PLACE,
      ST_RESP
   } samt_state_type;

   typedef struct packed {
      logic [MOD_W-1:0]  module_id;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } samt_entry_type;

   // request context seen by the slot evaluator
   typedef struct packed {
      logic [NUM_W-1:0]  num;
      logic [ADDR_W-1:0] start;
      logic              len_zero;
      logic [ADDR_W:0]   new_sum;
      logic [ADDR_W-1:0] new_page;
      logic [ADDR_W:0]   new_page_end;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] page_base;
      logic [LEN_W-1:0]  page_size;
   } samt_ctx_type;

   // per-slot result of the slot evaluator
   typedef struct packed {
      logic             busy;
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             clash;
      logic             covers_addr;
      logic             num_match;
      logic             less;
      samt_entry_type   entry;
   } samt_res_type;

endpackage

>>> src/samt_if.sv
`timescale 1ns / 1ps
// samt_req_if and samt_rsp_if: request and response channels of the address map
// depends on samt_pkg

interface samt_req_if import samt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [NUM_W-1:0]  module_num;
   logic [ADDR_W-1:0] region_start;
   logic [LEN_W-1:0]  region_length;
   logic [ADDR_W-1:0] address;

   modport source (output valid, kind, module_num, region_start, region_length, address,
                   input ready);
   modport sink (input valid, kind, module_num, region_start, region_length, address,
                 output ready);
endinterface

interface samt_rsp_if import samt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MOD_W-1:0]    hit_module;
   logic [ADDR_W-1:0]   hit_start;
   logic [LEN_W-1:0]    hit_length;
   logic [CNT_W-1:0]    slots_used;

   modport source (output valid, status, hit_module, hit_start, hit_length, slots_used,
                   input ready);
   modport sink (input valid, status, hit_module, hit_start, hit_length, slots_used,
                 output ready);
endinterface

>>> src/samt_ram.sv
`timescale 1ns / 1ps
// samt_ram: generic single write port, single read port ram with registered read
// no dependencies

module samt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/samt_eval.sv
`timescale 1ns / 1ps
// samt_eval: three-stage slot evaluator, one stored slot per cycle
// checks clash, address coverage, number match and sort order; depends on samt_pkg

module samt_eval import samt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             issue,
   input  logic [IDX_W-1:0] issue_idx,
   input  samt_entry_type   entry,
   input  samt_ctx_type     ctx,
   output samt_res_type     res
);

   // stage 1: slot just read from the table
   logic             v1_ff;
   logic [IDX_W-1:0] idx1_ff;

   // stage 2
   logic             v2_ff;
   logic [IDX_W-1:0] idx2_ff;
   samt_entry_type   e2_ff;
   logic [ADDR_W:0]  sum2_ff, sum2_in;
   logic [PROD_W-1:0] prod2_ff, prod2_in;
   logic             less2_ff, less2_in;
   logic             match2_ff, match2_in;
   logic             covlo2_ff, covlo2_in;
   logic             lz2_ff, lz2_in;

   // stage 3
   logic              v3_ff;
   logic [IDX_W-1:0]  idx3_ff;
   samt_entry_type    e3_ff;
   logic [ADDR_W-1:0] page3_ff, page3_in;
   logic              wrap3_ff, wrap3_in;
   logic              rcov3_ff, rcov3_in;
   logic              rmeet3_ff, rmeet3_in;
   logic              less3_ff, match3_ff, lz3_ff;

   logic [ADDR_W:0] page_sum;
   logic            page_wrap;
   logic            page_meet;
   logic            page_cover;

   always_comb begin
      sum2_in   = {1'b0, entry.start} + (ADDR_W + 1)'(entry.length);
      prod2_in  = PROD_W'(entry.module_id) * PROD_W'(ctx.page_size);
      less2_in  = entry.start < ctx.start;
      match2_in = NUM_W'(entry.module_id) == ctx.num;
      covlo2_in = ctx.addr >= entry.start;
      lz2_in    = entry.length == '0;
   end

   always_comb begin
      page3_in  = ctx.page_base + ADDR_W'(prod2_ff);
      wrap3_in  = sum2_ff[ADDR_W];
      rcov3_in  = covlo2_ff && ({1'b0, ctx.addr} < sum2_ff);
      rmeet3_in = ({1'b0, ctx.start} < sum2_ff) && ({1'b0, e2_ff.start} < ctx.new_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff   <= issue_idx;
      idx2_ff   <= idx1_ff;
      e2_ff     <= entry;
      sum2_ff   <= sum2_in;
      prod2_ff  <= prod2_in;
      less2_ff  <= less2_in;
      match2_ff <= match2_in;
      covlo2_ff <= covlo2_in;
      lz2_ff    <= lz2_in;
      idx3_ff   <= idx2_ff;
      e3_ff     <= e2_ff;
      page3_ff  <= page3_in;
      wrap3_ff  <= wrap3_in;
      rcov3_ff  <= rcov3_in;
      rmeet3_ff <= rmeet3_in;
      less3_ff  <= less2_ff;
      match3_ff <= match2_ff;
      lz3_ff    <= lz2_ff;
   end

   always_comb begin
      page_sum   = {1'b0, page3_ff} + (ADDR_W + 1)'(ctx.page_size);
      page_wrap  = page_sum[ADDR_W] || ctx.new_page_end[ADDR_W];
      page_meet  = ({1'b0, ctx.new_page} < page_sum) &&
                   ({1'b0, page3_ff} < ctx.new_page_end);
      page_cover = (ctx.addr >= page3_ff) && ({1'b0, ctx.addr} < page_sum);

      res.busy        = v1_ff || v2_ff || v3_ff;
      res.valid       = v3_ff;
      res.idx         = idx3_ff;
      res.num_match   = match3_ff;
      res.less        = less3_ff;
      res.covers_addr = rcov3_ff || page_cover;
      res.entry       = e3_ff;
      res.clash       = match3_ff ||
                        (!lz3_ff && !ctx.len_zero &&
                         (wrap3_ff || ctx.new_sum[ADDR_W] || rmeet3_ff ||
                          ((ctx.page_size != '0) && (page_wrap || page_meet))));
   end

endmodule

>>> src/sorted_address_map_table_core.sv
`timescale 1ns / 1ps
// sorted_address_map_table_core: sorted bus slot table with add, remove and lookups
// depends on samt_pkg, samt_if, samt_ram and samt_eval
// a request walks all n stored slots through the slot evaluator before it acts
// lookup, or remove of a missing number: response; remove: m slots above the hit move down
// add: walk, m slots move up, new slot placed; overlap: no write; bad number or full: no walk
// one request at a time, set by the slot evaluator walking the table ram once per slot
// reset: table empty, io page base 0, io page size 4096; no clearing pass needed

module sorted_address_map_table_core import samt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   samt_req_if.sink               req_bus,
   samt_rsp_if.source             rsp_bus
);

   samt_state_type state_ff, state_in;

   logic [ADDR_W-1:0] page_base_ff, page_base_in;
   logic [LEN_W-1:0]  page_size_ff, page_size_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   samt_kind_type     kind_ff, kind_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ADDR_W:0]   new_sum_ff, new_sum_in;
   logic [ADDR_W-1:0] new_page_ff, new_page_in;
   logic [ADDR_W:0]   new_page_end_ff, new_page_end_in;

   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              clash_ff, clash_in;
   logic [CNT_W-1:0]  less_cnt_ff, less_cnt_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   samt_entry_type    hit_entry_ff, hit_entry_in;
   samt_status_type   status_ff, status_in;

   logic [CNT_W-1:0]  shift_cnt_ff, shift_cnt_in;
   logic [IDX_W-1:0]  src_ff, src_in;
   logic [IDX_W-1:0]  dest_ff, dest_in;
   logic              pend_ff, pend_in;
   logic              shift_up_ff, shift_up_in;

   logic                rsp_valid_ff, rsp_valid_in;
   samt_status_type     rsp_status_ff, rsp_status_in;
   logic [MOD_W-1:0]    rsp_module_ff, rsp_module_in;
   logic [ADDR_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;
   logic [CNT_W-1:0]    rsp_used_ff, rsp_used_in;

   logic                req_accept;
   logic                bad_num;
   logic                table_full;
   logic                scan_done;
   logic                hit_cond;
   logic                is_lookup;
   logic                rsp_free;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   samt_entry_type      ram_wr_data;
   logic [IDX_W-1:0]    ram_rd_addr;
   samt_entry_type      ram_rd_data;
   logic                issue;

   samt_ctx_type        ctx;
   samt_res_type        res;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign bad_num       = {1'b0, req_bus.module_num} >= (NUM_W + 1)'(MAP_SLOTS);
   assign table_full    = count_ff >= CNT_W'(MAP_SLOTS);
   assign scan_done     = (scan_idx_ff == count_ff) && !res.busy;
   assign hit_cond      = (kind_ff == KIND_LOOKUP_ADDR) ? res.covers_addr : res.num_match;
   assign is_lookup     = (kind_ff == KIND_LOOKUP_ADDR) || (kind_ff == KIND_LOOKUP_NUM);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      ctx.num          = num_ff;
      ctx.start        = start_ff;
      ctx.len_zero     = len_ff == '0;
      ctx.new_sum      = new_sum_ff;
      ctx.new_page     = new_page_ff;
      ctx.new_page_end = new_page_end_ff;
      ctx.addr         = addr_ff;
      ctx.page_base    = page_base_ff;
      ctx.page_size    = page_size_ff;
   end

   samt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAP_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   samt_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .issue_idx (scan_idx_ff[IDX_W-1:0]),
      .entry     (ram_rd_data),
      .ctx       (ctx),
      .res       (res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (samt_kind_type'(req_bus.kind) == KIND_ADD) begin
                  if (bad_num || table_full) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_PREP_MUL;
                  end
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_PREP_MUL:  state_in = ST_PREP_PAGE;
         ST_PREP_PAGE: state_in = ST_PREP_END;
         ST_PREP_END:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_done) begin
               case (kind_ff)
                  KIND_ADD:    state_in = clash_ff ? ST_RESP : ST_SHIFT;
                  KIND_REMOVE: state_in = found_ff ? ST_SHIFT : ST_RESP;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_SHIFT: begin
            if (shift_cnt_ff == '0 && !pend_ff) begin
               state_in = shift_up_ff ? ST_PLACE : ST_RESP;
            end
         end
         ST_PLACE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      page_base_in    = page_base_ff;
      page_size_in    = page_size_ff;
      count_in        = count_ff;
      kind_in         = kind_ff;
      num_in          = num_ff;
      start_in        = start_ff;
      len_in          = len_ff;
      addr_in         = addr_ff;
      prod_in         = prod_ff;
      new_sum_in      = new_sum_ff;
      new_page_in     = new_page_ff;
      new_page_end_in = new_page_end_ff;
      scan_idx_in     = scan_idx_ff;
      clash_in        = clash_ff;
      less_cnt_in     = less_cnt_ff;
      found_in        = found_ff;
      hit_idx_in      = hit_idx_ff;
      hit_entry_in    = hit_entry_ff;
      status_in       = status_ff;
      shift_cnt_in    = shift_cnt_ff;
      src_in          = src_ff;
      dest_in         = dest_ff;
      pend_in         = pend_ff;
      shift_up_in     = shift_up_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_module_in   = rsp_module_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_used_in     = rsp_used_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = dest_ff;
      ram_wr_data     = ram_rd_data;
      ram_rd_addr     = scan_idx_ff[IDX_W-1:0];
      issue           = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PAGE_BASE: page_base_in = csr_data;
            CSR_PAGE_SIZE: page_size_in = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in     = samt_kind_type'(req_bus.kind);
               num_in      = req_bus.module_num;
               start_in    = req_bus.region_start;
               len_in      = req_bus.region_length;
               addr_in     = req_bus.address;
               scan_idx_in = '0;
               clash_in    = 1'b0;
               less_cnt_in = '0;
               found_in    = 1'b0;
               status_in   = STATUS_OK;
               if (samt_kind_type'(req_bus.kind) == KIND_ADD) begin
                  if (bad_num) begin
                     status_in = STATUS_BAD_NUM;
                  end else if (table_full) begin
                     status_in = STATUS_FULL;
                  end
               end
            end
         end
         ST_PREP_MUL: begin
            prod_in    = PROD_W'(num_ff[MOD_W-1:0]) * PROD_W'(page_size_ff);
            new_sum_in = {1'b0, start_ff} + (ADDR_W + 1)'(len_ff);
         end
         ST_PREP_PAGE: begin
            new_page_in = page_base_ff + ADDR_W'(prod_ff);
         end
         ST_PREP_END: begin
            new_page_end_in = {1'b0, new_page_ff} + (ADDR_W + 1)'(page_size_ff);
         end
         ST_SCAN: begin
            issue = scan_idx_ff < count_ff;
            if (issue) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            if (res.valid) begin
               clash_in    = clash_ff || res.clash;
               less_cnt_in = less_cnt_ff + CNT_W'(res.less);
               if (!found_ff && hit_cond) begin
                  found_in     = 1'b1;
                  hit_idx_in   = res.idx;
                  hit_entry_in = res.entry;
               end
            end
            if (scan_done) begin
               pend_in = 1'b0;
               case (kind_ff)
                  KIND_ADD: begin
                     if (clash_ff) begin
                        status_in = STATUS_OVERLAP;
                     end else begin
                        shift_cnt_in = count_ff - less_cnt_ff;
                        src_in       = IDX_W'(count_ff - CNT_W'(1));
                        shift_up_in  = 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!found_ff) begin
                        status_in = STATUS_NOT_FOUND;
                     end else begin
                        shift_cnt_in = count_ff - CNT_W'(1) - CNT_W'(hit_idx_ff);
                        src_in       = hit_idx_ff + IDX_W'(1);
                        shift_up_in  = 1'b0;
                        count_in     = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     status_in = found_ff ? STATUS_OK : STATUS_NOT_FOUND;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            ram_rd_addr = src_ff;
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
            if (shift_cnt_ff != '0) begin
               pend_in      = 1'b1;
               dest_in      = shift_up_ff ? src_ff + IDX_W'(1) : src_ff - IDX_W'(1);
               src_in       = shift_up_ff ? src_ff - IDX_W'(1) : src_ff + IDX_W'(1);
               shift_cnt_in = shift_cnt_ff - CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_PLACE: begin
            ram_wr_en             = 1'b1;
            ram_wr_addr           = less_cnt_ff[IDX_W-1:0];
            ram_wr_data.module_id = num_ff[MOD_W-1:0];
            ram_wr_data.start     = start_ff;
            ram_wr_data.length    = len_ff;
            count_in              = count_ff + CNT_W'(1);
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_used_in   = count_ff;
               if (is_lookup && found_ff) begin
                  rsp_module_in = hit_entry_ff.module_id;
                  rsp_start_in  = hit_entry_ff.start;
                  rsp_length_in = hit_entry_ff.length;
               end else begin
                  rsp_module_in = '0;
                  rsp_start_in  = '0;
                  rsp_length_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_base_ff <= PAGE_BASE_RESET;
         page_size_ff <= PAGE_SIZE_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         shift_cnt_ff <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_base_ff <= page_base_in;
         page_size_ff <= page_size_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         shift_cnt_ff <= shift_cnt_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      num_ff          <= num_in;
      start_ff        <= start_in;
      len_ff          <= len_in;
      addr_ff         <= addr_in;
      prod_ff         <= prod_in;
      new_sum_ff      <= new_sum_in;
      new_page_ff     <= new_page_in;
      new_page_end_ff <= new_page_end_in;
      clash_ff        <= clash_in;
      less_cnt_ff     <= less_cnt_in;
      found_ff        <= found_in;
      hit_idx_ff      <= hit_idx_in;
      hit_entry_ff    <= hit_entry_in;
      status_ff       <= status_in;
      src_ff          <= src_in;
      dest_ff         <= dest_in;
      shift_up_ff     <= shift_up_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_module_ff   <= rsp_module_in;
      rsp_start_ff    <= rsp_start_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_used_ff     <= rsp_used_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.hit_module = rsp_module_ff;
   assign rsp_bus.hit_start  = rsp_start_ff;
   assign rsp_bus.hit_length = rsp_length_ff;
   assign rsp_bus.slots_used = rsp_used_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAP_SLOTS))
      else $error("slot count beyond table size");

   a_ram_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_SHIFT || state_ff == ST_PLACE))
      else $error("table write outside shift or place");

   a_eval_scan: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> state_ff == ST_SCAN)
      else $error("slot result outside scan");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_PLACE || state_ff == ST_SCAN) |=> $stable(count_ff))
      else $error("slot count changed outside scan or place");

   a_place_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> count_ff < CNT_W'(MAP_SLOTS))
      else $error("insert into full table");

endmodule

>>> tb/sv/samt_map_checker.sv
`timescale 1ns / 1ps
// samt_map_checker: watches the request, response and csr ports of the address map
// keeps its own sorted slot table, predicts each response and compares field by field
// depends on samt_pkg and samt_if

module samt_map_checker import samt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   samt_req_if                    req_bus,
   samt_rsp_if                    rsp_bus,
   output int                     mismatch_count,
   output int                     open_requests
);

   typedef struct {
      samt_status_type   status;
      logic [MOD_W-1:0]  module_id;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
      logic [CNT_W-1:0]  used;
   } map_reply_type;

   logic [MOD_W-1:0]  map_module [MAP_SLOTS];
   logic [ADDR_W-1:0] map_start  [MAP_SLOTS];
   logic [LEN_W-1:0]  map_length [MAP_SLOTS];
   int                map_count;
   logic [ADDR_W-1:0] page_base;
   logic [LEN_W-1:0]  page_size;
   map_reply_type     expected_replies [$];

   function automatic logic [ADDR_W-1:0] page_addr(input logic [ADDR_W-1:0] num);
      return page_base + num * ADDR_W'(page_size);
   endfunction

   function automatic bit runs_past_top(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] len);
      return len > ~s;
   endfunction

   function automatic bit ranges_meet(input logic [ADDR_W-1:0] a_start, a_len, b_start, b_len);
      logic [ADDR_W-1:0] a_end;
      logic [ADDR_W-1:0] b_end;
      a_end = a_start + a_len - ADDR_W'(1);
      b_end = b_start + b_len - ADDR_W'(1);
      return a_start <= b_end && a_end >= b_start;
   endfunction

   function automatic bit addr_in(input logic [ADDR_W-1:0] s, len, adr);
      return adr >= s && (adr - s) < len;
   endfunction

   function automatic bit slots_conflict(input logic [ADDR_W-1:0] a_mod, a_start, a_len,
                                         input logic [ADDR_W-1:0] b_mod, b_start, b_len);
      logic [ADDR_W-1:0] a_page;
      logic [ADDR_W-1:0] b_page;
      logic [ADDR_W-1:0] page_len;
      page_len = ADDR_W'(page_size);
      if (a_mod == b_mod) return 1'b1;
      if (a_len == 0 || b_len == 0) return 1'b0;
      if (runs_past_top(a_start, a_len) || runs_past_top(b_start, b_len)) return 1'b1;
      if (ranges_meet(a_start, a_len, b_start, b_len)) return 1'b1;
      if (page_len == 0) return 1'b0;
      a_page = page_addr(a_mod);
      b_page = page_addr(b_mod);
      if (runs_past_top(a_page, page_len) || runs_past_top(b_page, page_len)) return 1'b1;
      return ranges_meet(a_page, page_len, b_page, page_len);
   endfunction

   function automatic int slot_of_module(input logic [ADDR_W-1:0] num);
      for (int i = 0; i < map_count; i++)
         if (ADDR_W'(map_module[i]) == num) return i;
      return -1;
   endfunction

   task automatic predict_request(input samt_kind_type kind, input logic [NUM_W-1:0] num,
                                  input logic [ADDR_W-1:0] rs, input logic [LEN_W-1:0] rl,
                                  input logic [ADDR_W-1:0] adr, output map_reply_type reply);
      int hit;
      int pos;
      reply.status    = STATUS_OK;
      reply.module_id = '0;
      reply.start     = '0;
      reply.length    = '0;
      hit = -1;
      case (kind)
         KIND_ADD: begin
            if (num >= MAP_SLOTS) begin
               reply.status = STATUS_BAD_NUM;
            end else if (map_count >= MAP_SLOTS) begin
               reply.status = STATUS_FULL;
            end else begin
               for (int i = 0; i < map_count; i++) begin
                  if (slots_conflict(ADDR_W'(map_module[i]), map_start[i],
                                     ADDR_W'(map_length[i]), ADDR_W'(num), rs,
                                     ADDR_W'(rl))) begin
                     reply.status = STATUS_OVERLAP;
                     break;
                  end
               end
               if (reply.status == STATUS_OK) begin
                  pos = 0;
                  while (pos < map_count && map_start[pos] < rs) pos++;
                  for (int i = map_count; i > pos; i--) begin
                     map_module[i] = map_module[i-1];
                     map_start[i]  = map_start[i-1];
                     map_length[i] = map_length[i-1];
                  end
                  map_module[pos] = num[MOD_W-1:0];
                  map_start[pos]  = rs;
                  map_length[pos] = rl;
                  map_count++;
               end
            end
         end
         KIND_REMOVE: begin
            hit = slot_of_module(ADDR_W'(num));
            if (hit < 0) begin
               reply.status = STATUS_NOT_FOUND;
            end else begin
               for (int i = hit; i + 1 < map_count; i++) begin
                  map_module[i] = map_module[i+1];
                  map_start[i]  = map_start[i+1];
                  map_length[i] = map_length[i+1];
               end
               map_count--;
            end
         end
         default: begin
            if (kind == KIND_LOOKUP_ADDR) begin
               for (int i = 0; i < map_count; i++) begin
                  if (addr_in(map_start[i], ADDR_W'(map_length[i]), adr) ||
                      addr_in(page_addr(ADDR_W'(map_module[i])), ADDR_W'(page_size), adr)) begin
                     hit = i;
                     break;
                  end
               end
            end else begin
               hit = slot_of_module(ADDR_W'(num));
            end
            if (hit < 0) begin
               reply.status = STATUS_NOT_FOUND;
            end else begin
               reply.module_id = map_module[hit];
               reply.start     = map_start[hit];
               reply.length    = map_length[hit];
            end
         end
      endcase
      reply.used = CNT_W'(map_count);
   endtask

   task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      map_reply_type expected;
      if (reset) begin
         map_count      = 0;
         page_base      = PAGE_BASE_RESET;
         page_size      = PAGE_SIZE_RESET;
         mismatch_count = 0;
         expected_replies.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with no request outstanding", $time);
            end else begin
               expected = expected_replies.pop_front();
               check_field("status", ADDR_W'(expected.status), ADDR_W'(rsp_bus.status));
               check_field("hit_module", ADDR_W'(expected.module_id),
                           ADDR_W'(rsp_bus.hit_module));
               check_field("hit_start", expected.start, rsp_bus.hit_start);
               check_field("hit_length", ADDR_W'(expected.length), ADDR_W'(rsp_bus.hit_length));
               check_field("slots_used", ADDR_W'(expected.used), ADDR_W'(rsp_bus.slots_used));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_request(samt_kind_type'(req_bus.kind), req_bus.module_num,
                            req_bus.region_start, req_bus.region_length, req_bus.address,
                            expected);
            expected_replies.push_back(expected);
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_PAGE_BASE) page_base = csr_data;
            else if (csr_index == CSR_PAGE_SIZE) page_size = csr_data[LEN_W-1:0];
         end
      end
      open_requests <= expected_replies.size();
   end

endmodule

>>> tb/sv/sorted_address_map_table_core_tb.sv
`timescale 1ns / 1ps
// sorted_address_map_table_core_tb: stimulus and verdict for the sorted address map
// drives directed and random requests over several page settings and idle and stall patterns
// depends on samt_pkg, samt_if, sorted_address_map_table_core and samt_map_checker

module sorted_address_map_table_core_tb;
   import samt_pkg::*;

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 178;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 60;
   localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     mismatch_count;
   int                     open_requests;
   int                     quiet_cycles = 0;
   int                     idle_pct = 0;
   int                     stall_pct = 0;
   logic [ADDR_W-1:0]      cur_base;
   logic [LEN_W-1:0]       cur_size;
   logic [ADDR_W-1:0]      hint_start [MAP_SLOTS];
   logic [LEN_W-1:0]       hint_len   [MAP_SLOTS];

   samt_req_if req_bus ();
   samt_rsp_if rsp_bus ();

   sorted_address_map_table_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   samt_map_checker map_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .open_requests  (open_requests)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input samt_kind_type kind, input logic [NUM_W-1:0] num,
                               input logic [ADDR_W-1:0] rs, input logic [LEN_W-1:0] rl,
                               input logic [ADDR_W-1:0] adr);
      int gap;
      gap = 0;
      while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= kind;
      req_bus.module_num    <= num;
      req_bus.region_start  <= rs;
      req_bus.region_length <= rl;
      req_bus.address       <= adr;
      if (kind == KIND_ADD && num < MAP_SLOTS) begin
         hint_start[num[MOD_W-1:0]] = rs;
         hint_len[num[MOD_W-1:0]]   = rl;
      end
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_PAGE_BASE) cur_base = data;
      else cur_size = data[LEN_W-1:0];
   endtask

   // lets the block drain and go idle
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (open_requests != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_request();
      samt_kind_type     kind;
      logic [NUM_W-1:0]  num;
      logic [MOD_W-1:0]  near;
      logic [ADDR_W-1:0] rs;
      logic [ADDR_W-1:0] adr;
      logic [LEN_W-1:0]  rl;
      int                roll;
      roll = $urandom_range(99);
      kind = roll < 35 ? KIND_ADD : roll < 55 ? KIND_REMOVE :
             roll < 80 ? KIND_LOOKUP_ADDR : KIND_LOOKUP_NUM;
      num  = ($urandom_range(9) == 0) ? NUM_W'($urandom_range(63, 16)) :
                                        NUM_W'($urandom_range(15));
      near = MOD_W'($urandom_range(15));
      case ($urandom_range(4))
         0: rs = {$urandom, $urandom};
         1: rs = ADDR_W'($urandom_range(32'h3000));
         2: rs = ADDR_TOP - ADDR_W'($urandom_range(32'h3000));
         3: rs = hint_start[near] + ADDR_W'($urandom_range(32)) - ADDR_W'(16);
         default: rs = 64'h0000_0001_0000_0000 + ADDR_W'({$urandom_range(255), 12'h000});
      endcase
      case ($urandom_range(5))
         0: rl = '0;
         1: rl = '1;
         2: rl = $urandom;
         default: rl = LEN_W'($urandom_range(32'h2000, 1));
      endcase
      case ($urandom_range(5))
         0, 1: adr = hint_start[near] + ADDR_W'($urandom_range(hint_len[near]));
         2: adr = cur_base + ADDR_W'(near) * ADDR_W'(cur_size) + ADDR_W'($urandom_range(cur_size));
         3: adr = hint_start[near] - ADDR_W'(1);
         4: adr = {$urandom, $urandom};
         default: adr = ADDR_W'($urandom_range(32'h0010_0000));
      endcase
      send_request(kind, num, rs, rl, adr);
   endtask

   initial begin
      logic [ADDR_W-1:0] phase_base;
      logic [LEN_W-1:0]  phase_size;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_PAGE_BASE;
      csr_data              = '0;
      req_bus.valid         = 1'b0;
      req_bus.kind          = KIND_ADD;
      req_bus.module_num    = '0;
      req_bus.region_start  = '0;
      req_bus.region_length = '0;
      req_bus.address       = '0;
      cur_base              = PAGE_BASE_RESET;
      cur_size              = PAGE_SIZE_RESET;
      for (int i = 0; i < MAP_SLOTS; i++) begin
         hint_start[i] = '0;
         hint_len[i]   = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      write_csr(CSR_PAGE_BASE, PAGE_BASE_RESET);
      write_csr(CSR_PAGE_SIZE, CSR_DATA_W'(PAGE_SIZE_RESET));

      // empty table, bad numbers, first slot, clashes, zero length, equal starts, top of space, lookups, removes
      send_request(KIND_LOOKUP_NUM, 0, '0, '0, '0);
      send_request(KIND_LOOKUP_ADDR, 0, '0, '0, '0);
      send_request(KIND_REMOVE, 5, '0, '0, '0);
      send_request(KIND_ADD, 63, ADDR_TOP, '1, ADDR_TOP);
      send_request(KIND_ADD, 16, 64'h1000, 32'h10, '0);
      send_request(KIND_ADD, 0, 64'h0, 32'h1000, ADDR_TOP);
      send_request(KIND_ADD, 0, 64'h5000_0000, 32'h10, '0);
      send_request(KIND_ADD, 1, 64'h800, 32'h100, '0);
      send_request(KIND_ADD, 2, 64'h10_0000, 32'h0, '0);
      send_request(KIND_ADD, 3, 64'h10_0000, 32'h10, '0);
      send_request(KIND_ADD, 4, ADDR_TOP - 15, 32'd16, '0);
      send_request(KIND_ADD, 4, ADDR_TOP - 15, 32'd15, '0);
      send_request(KIND_ADD, 5, ADDR_TOP, '1, '0);
      send_request(KIND_ADD, 6, 64'h20_0000, '1, '0);
      send_request(KIND_LOOKUP_ADDR, 0, '0, '0, ADDR_TOP - 1);
      send_request(KIND_LOOKUP_ADDR, 0, '0, '0, ADDR_TOP);
      send_request(KIND_LOOKUP_ADDR, 0, '0, '0, 64'h2005);
      send_request(KIND_LOOKUP_ADDR, 0, '0, '0, 64'h10_0000);
      send_request(KIND_LOOKUP_NUM, 4, '0, '0, '0);
      send_request(KIND_LOOKUP_NUM, 15, '0, '0, '0);
      send_request(KIND_LOOKUP_NUM, 63, '0, '0, '0);
      send_request(KIND_REMOVE, 3, '0, '0, '0);
      send_request(KIND_REMOVE, 3, '0, '0, '0);
      send_request(KIND_REMOVE, 40, '0, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin phase_base = '0; phase_size = 32'd4096; end
            1: begin phase_base = 64'h8000_0000_0000_0000; phase_size = 32'h0001_0000; end
            2: begin phase_base = ADDR_TOP; phase_size = 32'd4096; end
            3: begin phase_base = '0; phase_size = 32'd1; end
            4: begin phase_base = {$urandom, $urandom}; phase_size = '1; end
            5: begin phase_base = 64'hFFFF_FFFF_FFFF_0000; phase_size = '0; end
            6: begin phase_base = '0; phase_size = '1; end
            default: begin phase_base = 64'h1000; phase_size = 32'd4096; end
         endcase
         write_csr(CSR_PAGE_BASE, phase_base);
         write_csr(CSR_PAGE_SIZE, CSR_DATA_W'(phase_size));
         idle_pct  = (p % 4 == 1) ? 83 : (p % 4 == 3) ? 9 : 0;
         stall_pct = (p % 4 == 2) ? 83 : (p % 4 == 3) ? 9 : 0;
         repeat (PHASE_ITEMS) random_request();
      end
      settle();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
